[rtl/core/ltq_pkg.sv]
// ----------------------------------------------------------------------------
// ltq_pkg
// Shared widths, command codes and record types of the lowest-id-first
// transmit queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ltq_pkg;

  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int FILL_W = 4;
  localparam int DROP_W = 16;

  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  // request command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // one queued frame
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } frame_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tok_t;

  // per-cell controls from the sequencer
  typedef struct packed {
    logic occupied;
    logic pick_min;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/lowest_id_first_transmit_queue.sv]
// ----------------------------------------------------------------------------
// lowest_id_first_transmit_queue
// Bounded frame queue that pops the lowest identifier first, earliest
// arrival first among equal identifiers, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request is one push or one pop and gives exactly one result. A push
// into a queue with room and a pop of an empty queue go from S_EXEC
// straight to S_RESULT. A pop, and a push that meets a full queue, also
// pass through S_SCAN and S_APPLY: a search token walks the row of slot
// cells one cell per clock to find the lowest identifier (pop) or the latest
// highest identifier (victim for a full push). A new request is accepted
// once the result has moved into the output register. The result register
// lets a new request in while the previous result still waits for
// out_ready. A full push always counts in drop_total (saturating at 65535)
// and replaces the victim only if its identifier is strictly lower.
// fill_level shows the count masked to 4 bits.
`default_nettype none

module lowest_id_first_transmit_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            cmd,
  input  wire  [ltq_pkg::ID_W-1:0]       frame_id,
  input  wire  [ltq_pkg::LEN_W-1:0]      frame_len,
  input  wire  [ltq_pkg::DATA_W-1:0]     frame_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           ok,
  output logic [ltq_pkg::ID_W-1:0]       out_id,
  output logic [ltq_pkg::LEN_W-1:0]      out_len,
  output logic [ltq_pkg::DATA_W-1:0]     out_data,
  output logic [ltq_pkg::FILL_W-1:0]     fill_level,
  output logic [ltq_pkg::DROP_W-1:0]     drop_total
);
  import ltq_pkg::*;

  localparam int POS_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_APPLY  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  count;
  logic [DROP_W-1:0] drop_cnt;
  logic [POS_W-1:0]  scan_cnt;

  // request held for the whole operation
  logic              item_cmd;
  logic [ID_W-1:0]   item_id;
  logic [LEN_W-1:0]  item_len;
  logic [DATA_W-1:0] item_data;

  // result waiting to move into the output register
  logic              res_ok;
  frame_t            res_frame;

  frame_t            wr_frame;
  frame_t            frames  [QUEUE_DEPTH];
  tok_t              tok     [QUEUE_DEPTH];
  logic [POS_W-1:0]  tpos    [QUEUE_DEPTH];
  cell_ctl_t         ctl     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] load_vec;

  tok_t              tail_tok;
  logic [POS_W-1:0]  tail_pos;
  logic              full;
  logic              replace;
  logic              ld_en;
  logic              shift_en;
  logic [CNT_W-1:0]  wr_idx;

  assign in_ready = (state == S_IDLE);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign tail_tok = tok[QUEUE_DEPTH-1];
  assign tail_pos = tpos[QUEUE_DEPTH-1];
  assign replace  = item_id < tail_tok.frame.id;
  assign wr_frame = '{id: item_id, len: item_len, data: item_data};

  // Decide slot writes and close-up for the current step
  always_comb begin
    ld_en    = 1'b0;
    shift_en = 1'b0;
    wr_idx   = count;
    unique case (state)
      S_EXEC: begin
        ld_en = (item_cmd == CMD_PUSH) && !full;
      end
      S_APPLY: begin
        if (item_cmd == CMD_POP) begin
          shift_en = 1'b1;
        end else if (replace) begin
          shift_en = 1'b1;
          ld_en    = 1'b1;
          wr_idx   = CNT_W'(QUEUE_DEPTH - 1);
        end
      end
      default: begin
      end
    endcase
  end

  // Row of slot cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tok_t             t_in;
    logic [POS_W-1:0] p_in;
    frame_t           r_frame;

    assign ctl[i].occupied = CNT_W'(i) < count;
    assign ctl[i].pick_min = (item_cmd == CMD_POP);
    assign ctl[i].load     = ld_en && (wr_idx == CNT_W'(i));
    assign load_vec[i]     = ctl[i].load;

    if (i == 0) begin : g_head
      assign t_in = '0;
      assign p_in = '0;
    end else begin : g_body
      assign t_in = tok[i-1];
      assign p_in = tpos[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_frame     = wr_frame;
      assign ctl[i].shift = 1'b0;
    end else begin : g_inner
      assign r_frame      = frames[i+1];
      assign ctl[i].shift = shift_en && (POS_W'(i) >= tail_pos);
    end

    ltq_cell #(
      .DEPTH (QUEUE_DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[i]),
      .wr_frame    (wr_frame),
      .right_frame (r_frame),
      .frame       (frames[i]),
      .tok_in      (t_in),
      .pos_in      (p_in),
      .tok_out     (tok[i]),
      .pos_out     (tpos[i])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      drop_cnt  <= '0;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load the output register or release it
      if (state == S_RESULT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          scan_cnt <= '0;
          if (item_cmd == CMD_PUSH) begin
            if (!full) begin
              count <= count + CNT_W'(1);
              state <= S_RESULT;
            end else begin
              if (drop_cnt != DROP_MAX) begin
                drop_cnt <= drop_cnt + DROP_W'(1);
              end
              state <= S_SCAN;
            end
          end else if (count == '0) begin
            state <= S_RESULT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + POS_W'(1);
          if (scan_cnt == POS_W'(QUEUE_DEPTH - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (item_cmd == CMD_POP) begin
            count <= count - CNT_W'(1);
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd  <= cmd;
      item_id   <= frame_id;
      item_len  <= frame_len;
      item_data <= frame_data;
    end
  end

  // Build the result
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_ok    <= (item_cmd == CMD_PUSH) ? !full : 1'b0;
      res_frame <= '0;
    end else if (state == S_APPLY) begin
      if (item_cmd == CMD_POP) begin
        res_ok    <= 1'b1;
        res_frame <= tail_tok.frame;
      end else begin
        res_ok    <= replace;
        res_frame <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!out_valid || out_ready)) begin
      ok         <= res_ok;
      out_id     <= res_frame.id;
      out_len    <= res_frame.len;
      out_data   <= res_frame.data;
      fill_level <= FILL_W'(count);
      drop_total <= drop_cnt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_token_found: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> tail_tok.hit)
    else $error("search token found no slot");

  a_single_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0(load_vec))
    else $error("more than one slot loaded");

  a_scan_stable: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |=> $stable(count))
    else $error("count moved during search");

  a_drop_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> drop_cnt >= $past(drop_cnt))
    else $error("drop count decreased");

endmodule

`default_nettype wire

[rtl/core/ltq_cell.sv]
// ----------------------------------------------------------------------------
// ltq_cell
// One queue slot: holds a frame, closes up from its right neighbor, and
// passes a registered search token on to its left-to-right successor.
// ----------------------------------------------------------------------------
`default_nettype none

module ltq_cell #(
  parameter int DEPTH = 8,
  parameter int INDEX = 0
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire ltq_pkg::cell_ctl_t  ctl,
  input  wire ltq_pkg::frame_t     wr_frame,
  input  wire ltq_pkg::frame_t     right_frame,
  output ltq_pkg::frame_t          frame,
  input  wire ltq_pkg::tok_t       tok_in,
  input  wire [$clog2(DEPTH)-1:0]  pos_in,
  output ltq_pkg::tok_t            tok_out,
  output logic [$clog2(DEPTH)-1:0] pos_out
);
  import ltq_pkg::*;

  localparam int POS_W = $clog2(DEPTH);

  logic better;
  logic take_own;

  // Hold, load a new frame, or close up from the right neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      frame <= wr_frame;
    end else if (ctl.shift) begin
      frame <= right_frame;
    end
  end

  // Pop wants the first lowest id; the victim search wants the last highest
  always_comb begin
    if (ctl.pick_min) begin
      better = frame.id < tok_in.frame.id;
    end else begin
      better = frame.id >= tok_in.frame.id;
    end
    take_own = ctl.occupied && (!tok_in.hit || better);
  end

  // Advance the token one cell per clock
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.hit <= 1'b0;
    end else begin
      tok_out.hit <= take_own || tok_in.hit;
    end
    if (take_own) begin
      tok_out.frame <= frame;
      pos_out       <= POS_W'(INDEX);
    end else begin
      tok_out.frame <= tok_in.frame;
      pos_out       <= pos_in;
    end
  end

endmodule

`default_nettype wire

[tb/lowest_id_first_transmit_queue_tb.sv]
// ----------------------------------------------------------------------------
// lowest_id_first_transmit_queue_tb
// Self-checking bench for the lowest-id-first transmit queue. A directed
// table covers empty pops, extreme fields, full-queue displacement and
// tie ordering. Random phases follow with sender gaps, receiver stalls and
// a long receiver hold-off. Each result is checked against a queue model
// kept in the bench, or against the table row's own result where typed.
// ----------------------------------------------------------------------------
module lowest_id_first_transmit_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ltq_pkg::*;

  localparam int QDEPTH       = 8;
  localparam int PAUSE_CYCLES = QDEPTH + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 150;
  localparam int N_ROWS       = 26;

  localparam logic [ID_W-1:0]   ID_TOP   = '1;
  localparam logic [DATA_W-1:0] ONES     = '1;
  localparam logic              TYPED    = 1'b1;
  localparam logic              UNTYPED  = 1'b0;

  typedef enum int {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_RECEIVER_STALLS, FLOW_BOTH} flow_t;

  // one result as seen on the output port
  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [FILL_W-1:0] fill;
    logic [DROP_W-1:0] drops;
  } queue_result_t;

  // one row of the directed table
  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic              typed;
    queue_result_t     res;
  } step_row_t;

  localparam queue_result_t NO_RES = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                cmd = CMD_PUSH;
  logic [ID_W-1:0]     frame_id = '0;
  logic [LEN_W-1:0]    frame_len = '0;
  logic [DATA_W-1:0]   frame_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                ok;
  logic [ID_W-1:0]     out_id;
  logic [LEN_W-1:0]    out_len;
  logic [DATA_W-1:0]   out_data;
  logic [FILL_W-1:0]   fill_level;
  logic [DROP_W-1:0]   drop_total;

  // queue model and pending expectations
  frame_t              held_frames[$];
  logic [DROP_W-1:0]   drop_count = '0;
  queue_result_t       pending_results[$];

  flow_t               flow = FLOW_FREE;
  int                  fail_count = 0;
  int                  hold_requests = 0;
  int                  hold_served = 0;
  int                  hold_left = 0;
  int                  stuck_cycles = 0;
  step_row_t           directed_rows [N_ROWS];

  lowest_id_first_transmit_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .frame_id  (frame_id),
    .frame_len (frame_len),
    .frame_data(frame_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .out_id    (out_id),
    .out_len   (out_len),
    .out_data  (out_data),
    .fill_level(fill_level),
    .drop_total(drop_total)
  );

  always #5 clk = ~clk;

  function automatic queue_result_t outcome(logic o, logic [ID_W-1:0] i,
                                            logic [LEN_W-1:0] l, logic [DATA_W-1:0] d,
                                            logic [FILL_W-1:0] f, logic [DROP_W-1:0] dr);
    queue_result_t r;
    r.ok = o;
    r.id = i;
    r.len = l;
    r.data = d;
    r.fill = f;
    r.drops = dr;
    return r;
  endfunction

  // Apply one request to the queue model and return the result it gives.
  function automatic queue_result_t apply_request(logic c, logic [ID_W-1:0] fid,
                                                  logic [LEN_W-1:0] flen,
                                                  logic [DATA_W-1:0] fdata);
    queue_result_t r;
    frame_t        f;
    int            pick;
    r = '0;
    f.id = fid;
    f.len = flen;
    f.data = fdata;
    pick = 0;
    if (c == CMD_PUSH) begin
      if (held_frames.size() < QDEPTH) begin
        held_frames.push_back(f);
        r.ok = 1'b1;
      end else begin
        // victim: latest arrival among the highest identifiers
        for (int k = 1; k < held_frames.size(); k++)
          if (held_frames[k].id >= held_frames[pick].id) pick = k;
        if (drop_count != DROP_MAX) drop_count = drop_count + 1'b1;
        if (fid < held_frames[pick].id) begin
          held_frames.delete(pick);
          held_frames.push_back(f);
          r.ok = 1'b1;
        end
      end
    end else if (held_frames.size() > 0) begin
      // earliest arrival among the lowest identifiers
      for (int k = 1; k < held_frames.size(); k++)
        if (held_frames[k].id < held_frames[pick].id) pick = k;
      r.ok = 1'b1;
      r.id = held_frames[pick].id;
      r.len = held_frames[pick].len;
      r.data = held_frames[pick].data;
      held_frames.delete(pick);
    end
    r.fill = FILL_W'(held_frames.size());
    r.drops = drop_count;
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record its expectation.
  task automatic offer_request(input logic c, input logic [ID_W-1:0] fid,
                               input logic [LEN_W-1:0] flen,
                               input logic [DATA_W-1:0] fdata,
                               input logic use_typed, input queue_result_t typed_res);
    queue_result_t predicted;
    if (flow == FLOW_SENDER_GAPS || flow == FLOW_BOTH) begin
      while ($urandom_range(99) < 66) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    frame_id   <= fid;
    frame_len  <= flen;
    frame_data <= fdata;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_request(c, fid, flen, fdata);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  // Offer a random request; push_pct biases toward filling or draining.
  task automatic offer_random(input int push_pct);
    logic [ID_W-1:0] fid;
    logic [DATA_W-1:0] fdata;
    case ($urandom_range(9)) inside
      [0:4]:   fid = ID_W'($urandom_range(15));
      [5:6]:   fid = ID_W'($urandom_range(32'h1FFF_FFFF));
      7:       fid = ID_TOP;
      8:       fid = '0;
      default: fid = ID_W'($urandom);
    endcase
    case ($urandom_range(15))
      0:       fdata = '0;
      1:       fdata = ONES;
      default: fdata = {$urandom, $urandom};
    endcase
    offer_request(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, fid,
                  LEN_W'($urandom_range(15)), fdata, UNTYPED, NO_RES);
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  task automatic check_result;
    queue_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request pending");
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (ok !== want.ok) begin
        $error("ok expected %0d got %0d", want.ok, ok);
        fail_count++;
      end
      if (out_id !== want.id) begin
        $error("out_id expected %0h got %0h", want.id, out_id);
        fail_count++;
      end
      if (out_len !== want.len) begin
        $error("out_len expected %0d got %0d", want.len, out_len);
        fail_count++;
      end
      if (out_data !== want.data) begin
        $error("out_data expected %0h got %0h", want.data, out_data);
        fail_count++;
      end
      if (fill_level !== want.fill) begin
        $error("fill_level expected %0d got %0d", want.fill, fill_level);
        fail_count++;
      end
      if (drop_total !== want.drops) begin
        $error("drop_total expected %0d got %0d", want.drops, drop_total);
        fail_count++;
      end
    end
  endtask

  // Check results and drive out_ready: long hold-off, random stalls or open.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (flow == FLOW_RECEIVER_STALLS || flow == FLOW_BOTH) begin
      out_ready <= ($urandom_range(99) >= 66);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stop a hung run: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int push_pct;
    directed_rows = '{
      // pop on empty, then extremes of every field
      '{CMD_POP,  ID_W'(0),   4'd0,  64'd0,  TYPED,
        outcome(1'b0, ID_W'(0), 4'd0, 64'd0, 4'd0, 16'd0)},
      '{CMD_PUSH, ID_TOP,     4'd15, ONES,   TYPED,
        outcome(1'b1, ID_W'(0), 4'd0, 64'd0, 4'd1, 16'd0)},
      '{CMD_PUSH, ID_W'(0),   4'd0,  64'd0,  TYPED,
        outcome(1'b1, ID_W'(0), 4'd0, 64'd0, 4'd2, 16'd0)},
      '{CMD_POP,  ID_W'(0),   4'd0,  64'd0,  TYPED,
        outcome(1'b1, ID_W'(0), 4'd0, 64'd0, 4'd1, 16'd0)},
      '{CMD_POP,  ID_W'(0),   4'd0,  64'd0,  TYPED,
        outcome(1'b1, ID_TOP, 4'd15, ONES, 4'd0, 16'd0)},
      '{CMD_POP,  ID_W'(0),   4'd0,  64'd0,  TYPED,
        outcome(1'b0, ID_W'(0), 4'd0, 64'd0, 4'd0, 16'd0)},
      // fill with repeated identifiers
      '{CMD_PUSH, ID_W'(100), 4'd8,  64'h0102_0304_0506_0708, UNTYPED, NO_RES},
      '{CMD_PUSH, ID_W'(50),  4'd1,  64'h1111_2222_3333_4444, UNTYPED, NO_RES},
      '{CMD_PUSH, ID_W'(100), 4'd2,  64'h5555_6666_7777_8888, UNTYPED, NO_RES},
      '{CMD_PUSH, ID_W'(50),  4'd3,  64'h9999_AAAA_BBBB_CCCC, UNTYPED, NO_RES},
      '{CMD_PUSH, ID_W'(200), 4'd4,  64'hDDDD_EEEE_FFFF_0000, UNTYPED, NO_RES},
      '{CMD_PUSH, ID_W'(200), 4'd5,  64'hA5A5_A5A5_5A5A_5A5A, UNTYPED, NO_RES},
      '{CMD_PUSH, ID_W'(7),   4'd6,  64'h0F0F_F0F0_0F0F_F0F0, UNTYPED, NO_RES},
      '{CMD_PUSH, ID_W'(300), 4'd7,  64'hDEAD_BEEF_CAFE_F00D, UNTYPED, NO_RES},
      // full: equal and higher identifiers are refused, lower ones displace
      '{CMD_PUSH, ID_W'(300), 4'd8,  64'h1234_5678_9ABC_DEF0, TYPED,
        outcome(1'b0, ID_W'(0), 4'd0, 64'd0, 4'd8, 16'd1)},
      '{CMD_PUSH, ID_TOP,     4'd8,  ONES,                    TYPED,
        outcome(1'b0, ID_W'(0), 4'd0, 64'd0, 4'd8, 16'd2)},
      '{CMD_PUSH, ID_W'(150), 4'd9,  64'h8000_0000_0000_0001, TYPED,
        outcome(1'b1, ID_W'(0), 4'd0, 64'd0, 4'd8, 16'd3)},
      '{CMD_PUSH, ID_W'(1),   4'd12, 64'h7FFF_FFFF_FFFF_FFFE, TYPED,
        outcome(1'b1, ID_W'(0), 4'd0, 64'd0, 4'd8, 16'd4)},
      // drain: lowest first, arrival order among equals
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES},
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES},
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES},
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES},
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES},
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES},
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES},
      '{CMD_POP, ID_W'(0), 4'd0, 64'd0, UNTYPED, NO_RES}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    flow = FLOW_FREE;
    for (int r = 0; r < N_ROWS; r++)
      offer_request(directed_rows[r].cmd, directed_rows[r].id, directed_rows[r].len,
                    directed_rows[r].data, directed_rows[r].typed, directed_rows[r].res);
    drain_results();

    // hold the receiver off while requests, mostly pushes, keep coming, so the input stalls
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 20; n++) offer_random(80);
    drain_results();

    // random phases, one per idling pattern
    for (int p = 0; p < 4; p++) begin
      flow = flow_t'(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(3))
            0:       push_pct = 35;
            1:       push_pct = 55;
            2:       push_pct = 75;
            default: push_pct = 90;
          endcase
        end
        offer_random(push_pct);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ltq_pkg.sv
rtl/core/ltq_cell.sv
rtl/core/lowest_id_first_transmit_queue.sv
tb/lowest_id_first_transmit_queue_tb.sv
